/* sv/tbrl_pkg.sv */
package tbrl_pkg;

  // width of the configuration registers and of the token count fields
  localparam int unsigned CfgW = 32;
  localparam int unsigned RegIdxW = 2;
  localparam logic [CfgW-1:0] SizeReset = 32'hFFFF_FFFF;
  localparam logic [CfgW-1:0] OneReset = 32'd1;

  typedef enum logic [RegIdxW-1:0] {
    REG_TOKENS_PER_INTERVAL = 2'd0,
    REG_REFILL_INTERVAL     = 2'd1,
    REG_BUCKET_SIZE         = 2'd2
  } reg_idx_e;

  typedef enum logic {
    KIND_QUERY = 1'b0,
    KIND_TAKE  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_APPLY,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_step;
    logic apply;
    logic finish;
  } cmd_t;

endpackage

/* sv/tbrl_if.sv */
interface tbrl_in_if #(
  parameter int unsigned TIME_WIDTH = 48
);
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [tbrl_pkg::CfgW-1:0]  token_count;
  logic [TIME_WIDTH-1:0]      now_ticks;

  modport source(output valid, kind, token_count, now_ticks, input ready);
  modport sink(input valid, kind, token_count, now_ticks, output ready);
endinterface

interface tbrl_out_if;
  logic                       valid;
  logic                       ready;
  logic                       available;
  logic                       overdraw_error;
  logic [tbrl_pkg::CfgW-1:0]  tokens_left;

  modport source(output valid, available, overdraw_error, tokens_left, input ready);
  modport sink(input valid, available, overdraw_error, tokens_left, output ready);
endinterface

interface tbrl_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tbrl_pkg::RegIdxW-1:0]  index;
  logic [tbrl_pkg::CfgW-1:0]     data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* sv/tbrl_datapath.sv */
module tbrl_datapath #(
  parameter int unsigned TIME_WIDTH  = 48,
  parameter int unsigned TOKEN_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tbrl_pkg::cmd_t                    cmd_i,
  input  logic                              cfg_we_i,
  input  logic [tbrl_pkg::RegIdxW-1:0]      cfg_idx_i,
  input  logic [tbrl_pkg::CfgW-1:0]         cfg_data_i,
  input  logic                              in_kind_i,
  input  logic [tbrl_pkg::CfgW-1:0]         in_count_i,
  input  logic [TIME_WIDTH-1:0]             in_time_i,
  output logic                              avail_o,
  output logic                              err_o,
  output logic [tbrl_pkg::CfgW-1:0]         left_o
);

  localparam int unsigned CfgW = tbrl_pkg::CfgW;
  localparam int unsigned MaxW = (TOKEN_WIDTH > TIME_WIDTH) ? TOKEN_WIDTH : TIME_WIDTH;
  localparam int unsigned MulW = MaxW + 2;
  localparam int unsigned CmpW = (TOKEN_WIDTH > CfgW) ? TOKEN_WIDTH : CfgW;

  logic [CfgW-1:0]        tpi_q, ivl_q, size_q;
  logic [TOKEN_WIDTH-1:0] held_q;
  logic [TIME_WIDTH-1:0]  last_q;

  logic                   kind_q;
  logic [CfgW-1:0]        count_q;
  logic [TIME_WIDTH-1:0]  now_q;
  logic [TIME_WIDTH-1:0]  quo_q;
  logic [CfgW-1:0]        rem_q;
  logic [TOKEN_WIDTH-1:0] acc_q;
  logic [TOKEN_WIDTH-1:0] room_q;
  logic [CfgW-1:0]        mpl_q;
  logic                   sat_q;
  logic                   avail_q, err_q;
  logic [CfgW-1:0]        left_q;

  logic [TOKEN_WIDTH-1:0] cap;
  logic [CfgW-1:0]        ivl_eff;
  logic [TIME_WIDTH-1:0]  diff;
  logic [CfgW:0]          rem_sh;
  logic                   rem_ge;
  logic [CfgW:0]          rem_sub;
  logic [MulW-1:0]        mul_sum;
  logic                   mul_over;
  logic [TOKEN_WIDTH-1:0] refill_held;
  logic                   over;
  logic                   is_take;
  logic [TOKEN_WIDTH-1:0] res_held;

  always_comb begin
    cap      = TOKEN_WIDTH'(size_q);
    ivl_eff  = (ivl_q == '0) ? tbrl_pkg::OneReset : ivl_q;
    diff     = (in_time_i > last_q) ? (in_time_i - last_q) : '0;
    // restoring divide, one quotient bit per cycle
    rem_sh   = {rem_q, quo_q[TIME_WIDTH-1]};
    rem_ge   = rem_sh >= {1'b0, ivl_eff};
    rem_sub  = rem_sh - {1'b0, ivl_eff};
    // msb-first shift-add multiply, sticky once past the free room
    mul_sum  = MulW'({acc_q, 1'b0}) + (mpl_q[CfgW-1] ? MulW'(quo_q) : '0);
    mul_over = mul_sum > MulW'(room_q);
    refill_held = (sat_q || held_q >= cap) ? cap : (held_q + acc_q);
    is_take  = kind_q == tbrl_pkg::KIND_TAKE;
    over     = CmpW'(count_q) > CmpW'(held_q);
    res_held = (is_take && !over) ? (held_q - TOKEN_WIDTH'(count_q)) : held_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpi_q  <= tbrl_pkg::OneReset;
      ivl_q  <= tbrl_pkg::OneReset;
      size_q <= tbrl_pkg::SizeReset;
      held_q <= TOKEN_WIDTH'(tbrl_pkg::SizeReset);
      last_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tbrl_pkg::REG_TOKENS_PER_INTERVAL: tpi_q <= cfg_data_i;
        tbrl_pkg::REG_REFILL_INTERVAL:     ivl_q <= cfg_data_i;
        tbrl_pkg::REG_BUCKET_SIZE: begin
          size_q <= cfg_data_i;
          held_q <= TOKEN_WIDTH'(cfg_data_i);
        end
        default: ;
      endcase
    end else if (cmd_i.apply) begin
      if (quo_q != '0) begin
        held_q <= refill_held;
        last_q <= now_q - TIME_WIDTH'(rem_q);
      end
    end else if (cmd_i.finish) begin
      held_q <= res_held;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= in_kind_i;
      count_q <= in_count_i;
      now_q   <= in_time_i;
      quo_q   <= diff;
      rem_q   <= '0;
      acc_q   <= '0;
      mpl_q   <= tpi_q;
      sat_q   <= 1'b0;
      room_q  <= (held_q >= cap) ? '0 : (cap - held_q);
    end
    if (cmd_i.div_step) begin
      quo_q <= {quo_q[TIME_WIDTH-2:0], rem_ge};
      rem_q <= rem_ge ? rem_sub[CfgW-1:0] : rem_sh[CfgW-1:0];
    end
    if (cmd_i.mul_step) begin
      mpl_q <= {mpl_q[CfgW-2:0], 1'b0};
      if (mul_over) begin
        sat_q <= 1'b1;
      end else begin
        acc_q <= mul_sum[TOKEN_WIDTH-1:0];
      end
    end
    if (cmd_i.finish) begin
      avail_q <= !over;
      err_q   <= is_take && over;
      left_q  <= CfgW'(res_held);
    end
  end

  assign avail_o = avail_q;
  assign err_o   = err_q;
  assign left_o  = left_q;

endmodule

/* sv/tbrl_ctrl.sv */
module tbrl_ctrl #(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_kind_i,
  input  logic           out_ready_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output tbrl_pkg::cmd_t cmd_o
);

  localparam int unsigned CntMax = (TIME_WIDTH > tbrl_pkg::CfgW) ? TIME_WIDTH : tbrl_pkg::CfgW;
  localparam int unsigned CntW   = $clog2(CntMax);

  tbrl_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      tbrl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cnt_d   = CntW'(TIME_WIDTH - 1);
          state_d = (in_kind_i == tbrl_pkg::KIND_TAKE) ? tbrl_pkg::ST_FIN : tbrl_pkg::ST_DIV;
        end
      end
      tbrl_pkg::ST_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          cnt_d   = CntW'(tbrl_pkg::CfgW - 1);
          state_d = tbrl_pkg::ST_MUL;
        end
      end
      tbrl_pkg::ST_MUL: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = tbrl_pkg::ST_APPLY;
        end
      end
      tbrl_pkg::ST_APPLY: state_d = tbrl_pkg::ST_FIN;
      tbrl_pkg::ST_FIN: begin
        if (slot_free) begin
          state_d = tbrl_pkg::ST_IDLE;
        end
      end
      default: state_d = tbrl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      tbrl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      tbrl_pkg::ST_DIV:   cmd_o.div_step = 1'b1;
      tbrl_pkg::ST_MUL:   cmd_o.mul_step = 1'b1;
      tbrl_pkg::ST_APPLY: cmd_o.apply    = 1'b1;
      tbrl_pkg::ST_FIN:   cmd_o.finish   = slot_free;
      default: ;
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.finish;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tbrl_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command at once");

  a_finish_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("result written over an item not yet taken");

  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("finished item not presented");

  a_div_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tbrl_pkg::ST_DIV && cnt_q == '0) |=> (state_q == tbrl_pkg::ST_MUL))
    else $error("divide did not hand over to multiply");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != tbrl_pkg::ST_IDLE) |-> !in_ready_o)
    else $error("item taken while busy");
`endif

endmodule

/* sv/token_bucket_rate_limiter.sv */
// token bucket limiter, one item at a time, queries via serial divide and multiply
// query item: accept, divide, multiply, apply the refill, then finish
// take item: accept, then finish; finish waits while the output is stalled
// the next item is accepted only once the previous one has finished
// bit-serial divider (TIME_WIDTH steps), multiplier (32 steps) set the query rate
// async active-low reset: bucket full, last refill time zero, registers at defaults
module token_bucket_rate_limiter #(
  parameter int unsigned TIME_WIDTH  = 48,
  parameter int unsigned TOKEN_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tbrl_in_if.sink     in_i,
  tbrl_out_if.source  out_o,
  tbrl_cfg_if.sink    cfg_i
);

  tbrl_pkg::cmd_t cmd;
  logic           cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  tbrl_ctrl #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  tbrl_datapath #(
    .TIME_WIDTH (TIME_WIDTH),
    .TOKEN_WIDTH(TOKEN_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .in_kind_i  (in_i.kind),
    .in_count_i (in_i.token_count),
    .in_time_i  (in_i.now_ticks),
    .avail_o    (out_o.available),
    .err_o      (out_o.overdraw_error),
    .left_o     (out_o.tokens_left)
  );

endmodule

/* tb/tb_token_bucket_rate_limiter.sv */
module tb_token_bucket_rate_limiter;

  localparam int unsigned TimeW = 48;
  localparam int unsigned TokenW = 32;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
  localparam logic [tbrl_pkg::RegIdxW-1:0] RegSpare = 2'd3;
  localparam int QuietLimit = 2000;
  localparam int PhaseItems = 160;

  typedef struct packed {
    logic                        available;
    logic                        overdraw;
    logic [tbrl_pkg::CfgW-1:0]   tokens_left;
  } bucket_reply_t;

  typedef struct packed {
    logic [tbrl_pkg::RegIdxW-1:0] idx;
    logic [tbrl_pkg::CfgW-1:0]    data;
  } reg_write_t;

  // mirror of the bucket state plus the replies still owed by the block
  class bucket_tracker;
    logic [tbrl_pkg::CfgW-1:0]  tokens_per_ivl;
    logic [tbrl_pkg::CfgW-1:0]  refill_ivl;
    logic [tbrl_pkg::CfgW-1:0]  size;
    logic [tbrl_pkg::CfgW-1:0]  held;
    logic [TimeW-1:0]           last_refill;
    bucket_reply_t              owed[$];
    int                         errors;

    function new();
      tokens_per_ivl = tbrl_pkg::OneReset;
      refill_ivl     = tbrl_pkg::OneReset;
      size           = tbrl_pkg::SizeReset;
      held           = tbrl_pkg::SizeReset;
      last_refill    = '0;
      errors         = 0;
    endfunction

    function void write_reg(logic [tbrl_pkg::RegIdxW-1:0] idx,
                            logic [tbrl_pkg::CfgW-1:0] data);
      case (tbrl_pkg::reg_idx_e'(idx))
        tbrl_pkg::REG_TOKENS_PER_INTERVAL: tokens_per_ivl = data;
        tbrl_pkg::REG_REFILL_INTERVAL:     refill_ivl = data;
        tbrl_pkg::REG_BUCKET_SIZE: begin
          size = data;
          held = data;
        end
        default: ;
      endcase
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void note_item(tbrl_pkg::kind_e kind, logic [tbrl_pkg::CfgW-1:0] cnt,
                            logic [TimeW-1:0] now);
      bucket_reply_t r;
      logic [63:0]   ivl;
      logic [63:0]   elapsed;
      logic [63:0]   room;
      r.overdraw = 1'b0;
      if (kind == tbrl_pkg::KIND_QUERY) begin
        ivl = (refill_ivl == 0) ? 64'd1 : 64'(refill_ivl);
        elapsed = (now > last_refill) ? 64'(now - last_refill) / ivl : 64'd0;
        if (elapsed != 0) begin
          if (held >= size) begin
            held = size;
          end else begin
            room = 64'(size - held);
            // saturate instead of forming a product that could overflow
            if (tokens_per_ivl != 0 && elapsed > room / 64'(tokens_per_ivl))
              held = size;
            else
              held = held + tbrl_pkg::CfgW'(elapsed * 64'(tokens_per_ivl));
          end
          last_refill = last_refill + TimeW'(elapsed * ivl);
        end
        r.available = (cnt <= held);
      end else if (cnt > held) begin
        r.available = 1'b0;
        r.overdraw  = 1'b1;
      end else begin
        r.available = 1'b1;
        held = held - cnt;
      end
      r.tokens_left = held;
      owed.push_back(r);
    endfunction

    function void check_result(logic avail, logic ovd, logic [tbrl_pkg::CfgW-1:0] left);
      bucket_reply_t e;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected item expected none got avail=%0b ovd=%0b left=%0h",
                 $time, avail, ovd, left);
        return;
      end
      e = owed.pop_front();
      if (avail !== e.available) begin
        errors++;
        $display("%0t: available expected %0b got %0b", $time, e.available, avail);
      end
      if (ovd !== e.overdraw) begin
        errors++;
        $display("%0t: overdraw_error expected %0b got %0b", $time, e.overdraw, ovd);
      end
      if (left !== e.tokens_left) begin
        errors++;
        $display("%0t: tokens_left expected %0h got %0h", $time, e.tokens_left, left);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tbrl_in_if #(.TIME_WIDTH(TimeW)) in_if();
  tbrl_out_if out_if();
  tbrl_cfg_if cfg_if();

  token_bucket_rate_limiter #(
    .TIME_WIDTH (TimeW),
    .TOKEN_WIDTH(TokenW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  bucket_tracker sb = new();
  reg_write_t    reg_writes[$];
  bit            no_idle = 1'b0;
  bit            wide_times = 1'b0;
  int            quiet = 0;

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic [tbrl_pkg::CfgW-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return sb.held;
    if (r < 30) return sb.held + 1'b1;
    if (r < 45) return $urandom;
    return $urandom_range(0, sb.held);
  endfunction

  // mostly small steps past the last refill so the time base is not used up early
  function automatic logic [TimeW-1:0] pick_time();
    int unsigned r;
    logic [63:0] step;
    logic [63:0] sum;
    int unsigned back;
    if (wide_times) return TimeW'({$urandom, $urandom});
    r = $urandom_range(0, 99);
    if (r < 12) begin
      back = $urandom_range(1, 1000);
      return (64'(sb.last_refill) > back) ? sb.last_refill - back : '0;
    end
    if (r < 22) return sb.last_refill;
    if (r < 90)
      step = 64'(sb.refill_ivl) * $urandom_range(0, 3) + $urandom_range(0, sb.refill_ivl);
    else
      step = {$urandom_range(0, 15), $urandom};
    sum = 64'(sb.last_refill) + step;
    return (sum > 64'(TimeMax)) ? TimeW'({$urandom, $urandom}) : TimeW'(sum);
  endfunction

  task automatic send_item(tbrl_pkg::kind_e kind, logic [tbrl_pkg::CfgW-1:0] cnt,
                           logic [TimeW-1:0] now);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.kind        <= kind;
    in_if.token_count <= cnt;
    in_if.now_ticks   <= now;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(kind, cnt, now);
  endtask

  // writes go in only once every owed reply has come back
  task automatic apply_regs();
    reg_write_t w;
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_if.valid <= 1'b1;
      cfg_if.index <= w.idx;
      cfg_if.data  <= w.data;
      do @(posedge clk_i); while (!cfg_if.ready);
      sb.write_reg(w.idx, w.data);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_bucket(logic [tbrl_pkg::CfgW-1:0] tpi, logic [tbrl_pkg::CfgW-1:0] ivl,
                            logic [tbrl_pkg::CfgW-1:0] size);
    reg_writes.push_back('{tbrl_pkg::REG_TOKENS_PER_INTERVAL, tpi});
    reg_writes.push_back('{tbrl_pkg::REG_REFILL_INTERVAL, ivl});
    if ($urandom_range(0, 2) == 0) reg_writes.push_back('{RegSpare, $urandom});
    reg_writes.push_back('{tbrl_pkg::REG_BUCKET_SIZE, size});
    apply_regs();
  endtask

  task automatic run_random(int n);
    tbrl_pkg::kind_e kind;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      kind = tbrl_pkg::kind_e'($urandom_range(0, 1));
      send_item(kind, pick_count(),
                (kind == tbrl_pkg::KIND_QUERY) ? pick_time() : TimeW'({$urandom, $urandom}));
    end
  endtask

  // output side: random stall before each item, then hold ready until it comes
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      sb.check_result(out_if.available, out_if.overdraw_error, out_if.tokens_left);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet = 0;
    else
      quiet = quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    in_if.valid       <= 1'b0;
    in_if.kind        <= tbrl_pkg::KIND_QUERY;
    in_if.token_count <= '0;
    in_if.now_ticks   <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= '0;
    cfg_if.data       <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: full bucket, one token per tick
    send_item(tbrl_pkg::KIND_QUERY, '0, '0);
    send_item(tbrl_pkg::KIND_QUERY, '1, '0);
    send_item(tbrl_pkg::KIND_TAKE, '1, '0);
    send_item(tbrl_pkg::KIND_TAKE, 32'd1, '0);
    send_item(tbrl_pkg::KIND_QUERY, 32'd6, 48'd5);
    send_item(tbrl_pkg::KIND_QUERY, 32'd5, 48'd3);   // time runs backwards
    send_item(tbrl_pkg::KIND_TAKE, 32'd5, '1);

    // no tokens per interval and a zero interval
    set_bucket('0, '0, 32'd8);
    send_item(tbrl_pkg::KIND_TAKE, 32'd8, '0);
    send_item(tbrl_pkg::KIND_QUERY, '0, 48'd20);
    send_item(tbrl_pkg::KIND_QUERY, 32'd1, 48'd25);

    // refill product too large, bucket saturates
    set_bucket('1, 32'd4, '1);
    send_item(tbrl_pkg::KIND_TAKE, 32'hFFFF_FFFE, '0);
    send_item(tbrl_pkg::KIND_QUERY, 32'd2, 48'd33);
    send_item(tbrl_pkg::KIND_TAKE, 32'h8000_0000, '0);
    send_item(tbrl_pkg::KIND_QUERY, 32'h7FFF_FFFF, 48'd35);
    send_item(tbrl_pkg::KIND_TAKE, 32'h8000_0000, '0);

    set_bucket(32'd3, 32'd10, 32'd50);
    run_random(PhaseItems);
    set_bucket('0, 32'd7, 32'd20);
    run_random(PhaseItems);
    set_bucket(32'd1, '0, 32'd16);
    run_random(PhaseItems);
    set_bucket('1, 32'd1, '1);
    run_random(PhaseItems);
    set_bucket(32'd100, '1, 32'd1000);
    run_random(PhaseItems);
    set_bucket(32'd5, 32'd3, '0);
    run_random(PhaseItems);
    set_bucket($urandom_range(1, 50), $urandom_range(1, 20), $urandom_range(0, 200));
    run_random(PhaseItems);
    set_bucket(32'd1, 32'd1, '1);
    run_random(PhaseItems);

    // full-range times last, since they use up the forward time base
    wide_times = 1'b1;
    set_bucket($urandom, $urandom | 32'd1, $urandom);
    run_random(100);
    send_item(tbrl_pkg::KIND_QUERY, $urandom, TimeMax);

    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
